### hw/rtl/tabular_q_learning_engine_top_assert.svh
// Assertion macros for the tabular Q-learning engine.
`ifndef TABULAR_Q_LEARNING_ENGINE_TOP_ASSERT_SVH
`define TABULAR_Q_LEARNING_ENGINE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TQLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TQLE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TQLE_ASSERT(lbl, prop, msg)
`define TQLE_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### hw/rtl/tqle_pkg.sv
`default_nettype none
package tqle_pkg;
	localparam int STATE_W     = 8;
	localparam int ACT_W       = 3;
	localparam int VAL_W       = 16;
	localparam int NUM_ACTIONS = 8;
	localparam int ADDR_W      = STATE_W + ACT_W;
	localparam int DEPTH       = 1 << ADDR_W;
	localparam int FRAC_W      = 16;
	localparam int EPS_W       = 17;
	localparam int NACT_W      = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int CNT_W       = 4;

	localparam logic [FRAC_W-1:0] LEARN_RATE_RST   = 16'd6554;
	localparam logic [FRAC_W-1:0] DISCOUNT_RST     = 16'd58982;
	localparam logic [EPS_W-1:0]  EXPLORE_RATE_RST = 17'd6554;
	localparam logic              UPDATE_MODE_RST  = 1'b1;
	localparam logic [NACT_W-1:0] NUM_ACTIONS_RST  = 4'd8;

	localparam logic [VAL_W-1:0] VAL_MAX = 16'h7fff;
	localparam logic [VAL_W-1:0] VAL_MIN = 16'h8000;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_RATE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_MODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ACTIONS  = 3'd4;

	typedef enum logic [1:0] {
		CMD_SELECT = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_WRITE  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ADDR_CLEAR  = 2'd0,
		ADDR_SCAN   = 2'd1,
		ADDR_TARGET = 2'd2,
		ADDR_ENTRY  = 2'd3
	} addr_sel_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SCAN_END,
		ST_RD_TARGET,
		ST_RD_TARGET_W,
		ST_RD_Q,
		ST_RD_Q_W,
		ST_TERM,
		ST_SCALE,
		ST_RD_ENTRY,
		ST_RD_ENTRY_W,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic              capture;
		addr_sel_t         addr_sel;
		logic [ADDR_W-1:0] clr_addr;
		logic [ACT_W-1:0]  col;
		logic [ACT_W-1:0]  cmp_col;
		logic              clear_we;
		logic              scan_cmp;
		logic              scan_first;
		logic              load_target;
		logic              load_q;
		logic              calc_term;
		logic              calc_scale;
		logic              load_entry;
		logic              finish;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              explore;
		logic              q_mode;
		logic [NACT_W-1:0] n_act;
		logic              out_stall;
	} dp_status_t;
endpackage
`default_nettype wire

### hw/rtl/tqle_ram.sv
`default_nettype none
module tqle_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### hw/rtl/tqle_datapath.sv
`default_nettype none
module tqle_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [tqle_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tqle_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                          cmd,
	input  logic [tqle_pkg::STATE_W-1:0]        state_index,
	input  logic [tqle_pkg::ACT_W-1:0]          action_index,
	input  logic signed [tqle_pkg::VAL_W-1:0]   reward,
	input  logic [tqle_pkg::STATE_W-1:0]        succ_state,
	input  logic [tqle_pkg::ACT_W-1:0]          succ_action,
	input  logic [tqle_pkg::FRAC_W-1:0]         random_fraction,
	input  logic [tqle_pkg::ACT_W-1:0]          random_action,
	input  logic signed [tqle_pkg::VAL_W-1:0]   entry_value,
	input  tqle_pkg::ctl_cmd_t                  ctl,
	output tqle_pkg::dp_status_t                status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [tqle_pkg::ACT_W-1:0]          chosen_action,
	output logic signed [tqle_pkg::VAL_W-1:0]   table_value,
	output logic                                explored,
	output logic                                saturated
);
	// Configuration registers.
	logic [tqle_pkg::FRAC_W-1:0] learn_rate_q;
	logic [tqle_pkg::FRAC_W-1:0] discount_q;
	logic [tqle_pkg::EPS_W-1:0]  explore_rate_q;
	logic                        update_mode_q;
	logic [tqle_pkg::NACT_W-1:0] num_act_q;

	// Captured item.
	tqle_pkg::cmd_t               cmd_q;
	logic [tqle_pkg::STATE_W-1:0] s_q;
	logic [tqle_pkg::ACT_W-1:0]   a_q;
	logic [tqle_pkg::VAL_W-1:0]   r_q;
	logic [tqle_pkg::STATE_W-1:0] ns_q;
	logic [tqle_pkg::ACT_W-1:0]   na_q;
	logic [tqle_pkg::FRAC_W-1:0]  rf_q;
	logic [tqle_pkg::ACT_W-1:0]   ra_q;
	logic [tqle_pkg::VAL_W-1:0]   ev_q;

	// Working registers.
	logic signed [tqle_pkg::VAL_W-1:0] best_q;
	logic [tqle_pkg::ACT_W-1:0]        best_col_q;
	logic signed [tqle_pkg::VAL_W-1:0] target_q;
	logic signed [tqle_pkg::VAL_W-1:0] q_q;
	logic [tqle_pkg::VAL_W-1:0]        entry_q;
	logic signed [32:0]                prod_s1;
	logic [33:0]                       m_s2;
	logic                              neg_s2;
	logic [49:0]                       scaled_s3;

	logic                              out_valid_q;

	logic [tqle_pkg::NACT_W-1:0]  n_act;
	logic [tqle_pkg::ACT_W-1:0]   clamp_col;
	logic                         explore;
	logic [tqle_pkg::ACT_W-1:0]   entry_col;
	logic [tqle_pkg::ADDR_W-1:0]  ram_addr;
	logic                         ram_we;
	logic [tqle_pkg::VAL_W-1:0]   ram_wdata;
	logic [tqle_pkg::VAL_W-1:0]   ram_rdata;
	logic [34:0]                  term;
	logic [50:0]                  rounded;
	logic [20:0]                  mag21;
	logic [20:0]                  delta;
	logic [20:0]                  upd_sum;
	logic [tqle_pkg::VAL_W-1:0]   upd_val;
	logic                         upd_sat;
	logic [tqle_pkg::ACT_W-1:0]   res_chosen;
	logic [tqle_pkg::VAL_W-1:0]   res_value;
	logic                         res_explored;
	logic                         res_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q   <= tqle_pkg::LEARN_RATE_RST;
			discount_q     <= tqle_pkg::DISCOUNT_RST;
			explore_rate_q <= tqle_pkg::EXPLORE_RATE_RST;
			update_mode_q  <= tqle_pkg::UPDATE_MODE_RST;
			num_act_q      <= tqle_pkg::NUM_ACTIONS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tqle_pkg::CFG_LEARN_RATE:   learn_rate_q   <= cfg_data[15:0];
				tqle_pkg::CFG_DISCOUNT:     discount_q     <= cfg_data[15:0];
				tqle_pkg::CFG_EXPLORE_RATE: explore_rate_q <= cfg_data;
				tqle_pkg::CFG_UPDATE_MODE:  update_mode_q  <= cfg_data[0];
				tqle_pkg::CFG_NUM_ACTIONS:  num_act_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= tqle_pkg::cmd_t'(cmd);
			s_q   <= state_index;
			a_q   <= action_index;
			r_q   <= reward;
			ns_q  <= succ_state;
			na_q  <= succ_action;
			rf_q  <= random_fraction;
			ra_q  <= random_action;
			ev_q  <= entry_value;
		end
	end

	// Actions in use, limited to one through the table width.
	always_comb begin
		if (num_act_q == '0) begin
			n_act = 4'd1;
		end else if (num_act_q > 4'(tqle_pkg::NUM_ACTIONS)) begin
			n_act = 4'(tqle_pkg::NUM_ACTIONS);
		end else begin
			n_act = num_act_q;
		end
	end

	assign clamp_col = ({1'b0, ra_q} < n_act) ? ra_q : 3'(n_act - 4'd1);
	assign explore   = ({1'b0, rf_q} < explore_rate_q);
	assign entry_col = (cmd_q == tqle_pkg::CMD_SELECT) ? clamp_col : a_q;

	always_comb begin
		unique case (ctl.addr_sel)
			tqle_pkg::ADDR_CLEAR:  ram_addr = ctl.clr_addr;
			tqle_pkg::ADDR_SCAN:   ram_addr = {(cmd_q == tqle_pkg::CMD_UPDATE) ? ns_q : s_q,
				ctl.col};
			tqle_pkg::ADDR_TARGET: ram_addr = {ns_q, na_q};
			tqle_pkg::ADDR_ENTRY:  ram_addr = {s_q, entry_col};
			default:               ram_addr = ctl.clr_addr;
		endcase
	end

	assign ram_we = ctl.clear_we | (ctl.finish & ((cmd_q == tqle_pkg::CMD_UPDATE) |
		(cmd_q == tqle_pkg::CMD_WRITE)));
	assign ram_wdata = ctl.clear_we ? '0 : res_value;

	tqle_ram #(
		.WIDTH(tqle_pkg::VAL_W),
		.DEPTH(tqle_pkg::DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Row scan keeps the first maximal entry.
	always_ff @(posedge clk) begin
		if (ctl.scan_cmp && (ctl.scan_first || ($signed(ram_rdata) > best_q))) begin
			best_q     <= $signed(ram_rdata);
			best_col_q <= ctl.cmp_col;
		end
		if (ctl.load_target) begin
			target_q <= $signed(ram_rdata);
		end
		if (ctl.load_entry) begin
			entry_q <= ram_rdata;
		end
		if (ctl.load_q) begin
			q_q     <= $signed(ram_rdata);
			prod_s1 <= $signed({1'b0, discount_q}) * (update_mode_q ? best_q : target_q);
		end
		if (ctl.calc_term) begin
			neg_s2 <= term[34];
			m_s2   <= term[34] ? 34'(-term) : term[33:0];
		end
		if (ctl.calc_scale) begin
			scaled_s3 <= 50'(learn_rate_q) * 50'(m_s2);
		end
	end

	// Temporal difference term in units of 2^-24.
	assign term = {{3{r_q[15]}}, r_q, 16'd0} + {{2{prod_s1[32]}}, prod_s1}
		- {{3{q_q[15]}}, q_q, 16'd0};

	// Round half away from zero on the magnitude, then restore the sign.
	assign rounded = {1'b0, scaled_s3} + 51'h0_0000_8000_0000;
	assign mag21   = {2'b00, rounded[50:32]};
	assign delta   = neg_s2 ? -mag21 : mag21;
	assign upd_sum = {{5{q_q[15]}}, q_q} + delta;

	always_comb begin
		if ($signed(upd_sum) > $signed({{5{1'b0}}, tqle_pkg::VAL_MAX})) begin
			upd_val = tqle_pkg::VAL_MAX;
			upd_sat = 1'b1;
		end else if ($signed(upd_sum) < $signed({{5{1'b1}}, tqle_pkg::VAL_MIN})) begin
			upd_val = tqle_pkg::VAL_MIN;
			upd_sat = 1'b1;
		end else begin
			upd_val = upd_sum[15:0];
			upd_sat = 1'b0;
		end
	end

	always_comb begin
		res_chosen   = '0;
		res_value    = '0;
		res_explored = 1'b0;
		res_sat      = 1'b0;
		unique case (cmd_q)
			tqle_pkg::CMD_SELECT: begin
				res_chosen   = explore ? clamp_col : best_col_q;
				res_value    = explore ? entry_q : best_q;
				res_explored = explore;
			end
			tqle_pkg::CMD_UPDATE: begin
				res_value = upd_val;
				res_sat   = upd_sat;
			end
			tqle_pkg::CMD_WRITE: begin
				res_value = ev_q;
			end
			tqle_pkg::CMD_READ: begin
				res_value = entry_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			chosen_action <= res_chosen;
			table_value   <= res_value;
			explored      <= res_explored;
			saturated     <= res_sat;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.cmd       = cmd_q;
	assign status.explore   = explore;
	assign status.q_mode    = update_mode_q;
	assign status.n_act     = n_act;
	assign status.out_stall = out_valid_q & ~out_ready;
endmodule
`default_nettype wire

### hw/rtl/tqle_controller.sv
`default_nettype none
module tqle_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tqle_pkg::dp_status_t status,
	output tqle_pkg::ctl_cmd_t   ctl
);
	tqle_pkg::ctl_state_t state_q, state_d;
	logic [tqle_pkg::CNT_W-1:0]  col_q, col_d;
	logic [tqle_pkg::ADDR_W-1:0] clr_q, clr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tqle_pkg::ST_CLEAR;
			col_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			clr_q   <= clr_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		col_d        = col_q;
		clr_d        = clr_q;
		in_ready     = 1'b0;
		ctl          = '0;
		ctl.addr_sel = tqle_pkg::ADDR_CLEAR;
		unique case (state_q)
			tqle_pkg::ST_CLEAR: begin
				ctl.clear_we = 1'b1;
				ctl.clr_addr = clr_q;
				clr_d        = clr_q + 1'b1;
				if (&clr_q) begin
					state_d = tqle_pkg::ST_IDLE;
				end
			end
			tqle_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = tqle_pkg::ST_DISPATCH;
				end
			end
			tqle_pkg::ST_DISPATCH: begin
				col_d = '0;
				unique case (status.cmd)
					tqle_pkg::CMD_SELECT: state_d = status.explore ? tqle_pkg::ST_RD_ENTRY
						: tqle_pkg::ST_SCAN;
					tqle_pkg::CMD_UPDATE: state_d = status.q_mode ? tqle_pkg::ST_SCAN
						: tqle_pkg::ST_RD_TARGET;
					tqle_pkg::CMD_WRITE:  state_d = tqle_pkg::ST_DONE;
					tqle_pkg::CMD_READ:   state_d = tqle_pkg::ST_RD_ENTRY;
					default:              state_d = tqle_pkg::ST_DONE;
				endcase
			end
			tqle_pkg::ST_SCAN: begin
				// Read column col_q while comparing the word of the column before.
				ctl.addr_sel   = tqle_pkg::ADDR_SCAN;
				ctl.col        = col_q[tqle_pkg::ACT_W-1:0];
				ctl.scan_cmp   = (col_q != '0);
				ctl.scan_first = (col_q == 4'd1);
				ctl.cmp_col    = 3'(col_q - 4'd1);
				col_d          = col_q + 4'd1;
				if (col_q == status.n_act - 4'd1) begin
					state_d = tqle_pkg::ST_SCAN_END;
				end
			end
			tqle_pkg::ST_SCAN_END: begin
				ctl.scan_cmp   = 1'b1;
				ctl.scan_first = (col_q == 4'd1);
				ctl.cmp_col    = 3'(col_q - 4'd1);
				state_d        = (status.cmd == tqle_pkg::CMD_UPDATE) ? tqle_pkg::ST_RD_Q
					: tqle_pkg::ST_DONE;
			end
			tqle_pkg::ST_RD_TARGET: begin
				ctl.addr_sel = tqle_pkg::ADDR_TARGET;
				state_d      = tqle_pkg::ST_RD_TARGET_W;
			end
			tqle_pkg::ST_RD_TARGET_W: begin
				ctl.load_target = 1'b1;
				state_d         = tqle_pkg::ST_RD_Q;
			end
			tqle_pkg::ST_RD_Q: begin
				ctl.addr_sel = tqle_pkg::ADDR_ENTRY;
				state_d      = tqle_pkg::ST_RD_Q_W;
			end
			tqle_pkg::ST_RD_Q_W: begin
				ctl.load_q = 1'b1;
				state_d    = tqle_pkg::ST_TERM;
			end
			tqle_pkg::ST_TERM: begin
				ctl.calc_term = 1'b1;
				state_d       = tqle_pkg::ST_SCALE;
			end
			tqle_pkg::ST_SCALE: begin
				ctl.calc_scale = 1'b1;
				state_d        = tqle_pkg::ST_DONE;
			end
			tqle_pkg::ST_RD_ENTRY: begin
				ctl.addr_sel = tqle_pkg::ADDR_ENTRY;
				state_d      = tqle_pkg::ST_RD_ENTRY_W;
			end
			tqle_pkg::ST_RD_ENTRY_W: begin
				ctl.load_entry = 1'b1;
				state_d        = tqle_pkg::ST_DONE;
			end
			tqle_pkg::ST_DONE: begin
				ctl.addr_sel = tqle_pkg::ADDR_ENTRY;
				if (!status.out_stall) begin
					ctl.finish = 1'b1;
					state_d    = tqle_pkg::ST_IDLE;
				end
			end
			default: state_d = tqle_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### hw/rtl/tabular_q_learning_engine_top.sv
// Tabular Q-learning engine: a 256 x 8 table of signed Q8.8 values with
// epsilon-greedy action selection and SARSA or Q-learning updates.
// Input words (cmd and its fields) arrive on in_valid/in_ready; every word
// gives exactly one result word on out_valid/out_ready. Registers are loaded
// through cfg_write/cfg_index/cfg_data; the user must load them only while
// the engine is idle, as the block itself does not enforce this. One word
// is worked at a time; the single-port table RAM with its registered read
// sets the pace. After the result is registered the controller returns to
// idle and takes the next word. After reset the controller sweeps the table
// to zero, one entry a cycle, over all 2048 entries; in_ready stays low
// during the sweep while register writes are still taken. The result sits in
// an output register, so the engine goes back for the next word while a
// result waits; if the receiver stalls the finished word is held until the
// old one is taken.
`default_nettype none
`include "tabular_q_learning_engine_top_assert.svh"
module tabular_q_learning_engine_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [tqle_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tqle_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          cmd,
	input  logic [tqle_pkg::STATE_W-1:0]        state_index,
	input  logic [tqle_pkg::ACT_W-1:0]          action_index,
	input  logic signed [tqle_pkg::VAL_W-1:0]   reward,
	input  logic [tqle_pkg::STATE_W-1:0]        succ_state,
	input  logic [tqle_pkg::ACT_W-1:0]          succ_action,
	input  logic [tqle_pkg::FRAC_W-1:0]         random_fraction,
	input  logic [tqle_pkg::ACT_W-1:0]          random_action,
	input  logic signed [tqle_pkg::VAL_W-1:0]   entry_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tqle_pkg::ACT_W-1:0]          chosen_action,
	output logic signed [tqle_pkg::VAL_W-1:0]   table_value,
	output logic                                explored,
	output logic                                saturated
);
	tqle_pkg::ctl_cmd_t   ctl;
	tqle_pkg::dp_status_t status;

	// The controller sequences table reads, scans and the update arithmetic.
	tqle_controller u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.ctl     (ctl)
	);

	// The datapath holds the table, the registers and the result word.
	tqle_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.state_index    (state_index),
		.action_index   (action_index),
		.reward         (reward),
		.succ_state     (succ_state),
		.succ_action    (succ_action),
		.random_fraction(random_fraction),
		.random_action  (random_action),
		.entry_value    (entry_value),
		.ctl            (ctl),
		.status         (status),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.chosen_action  (chosen_action),
		.table_value    (table_value),
		.explored       (explored),
		.saturated      (saturated)
	);

	// Table writes happen only in the clearing sweep or at result time.
	`TQLE_ASSERT(a_no_write_when_ready, (ctl.clear_we || ctl.finish) |-> !in_ready, "table write")
	// Only one word is in work at a time.
	`TQLE_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready, "second word accepted")
	// A new result only appears when the controller hands one over.
	`TQLE_ASSERT(a_result_source, $rose(out_valid) |-> $past(ctl.finish), "result without finish")
	// Reset empties the output register.
	`TQLE_ASSERT_RST(a_reset_empty, !arst_n |-> !out_valid, "result valid in reset")
endmodule
`default_nettype wire

### tb/tabular_q_learning_engine_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none

// Self-checking bench for the tabular Q-learning engine.
// A short directed table exercises empty reads after reset, table extremes,
// greedy and exploring selection, the epsilon boundary and both update
// targets. A long random run follows, split into phases with different
// register settings. Every word taken by the engine is run through a
// predictor that keeps its own copy of the value table and registers. The
// expected results wait in a queue until the engine hands its result words out.
module tabular_q_learning_engine_top_tb;
	localparam int CLK_HALF    = 4;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_WORDS = 225;

	typedef struct {
		tqle_pkg::cmd_t                   op;
		logic [tqle_pkg::STATE_W-1:0]     st;
		logic [tqle_pkg::ACT_W-1:0]       act;
		logic signed [tqle_pkg::VAL_W-1:0] rew;
		logic [tqle_pkg::STATE_W-1:0]     nst;
		logic [tqle_pkg::ACT_W-1:0]       nact;
		logic [tqle_pkg::FRAC_W-1:0]      frac;
		logic [tqle_pkg::ACT_W-1:0]       ract;
		logic signed [tqle_pkg::VAL_W-1:0] ev;
		bit                               fixed;
		logic [tqle_pkg::ACT_W-1:0]       fx_act;
		logic signed [tqle_pkg::VAL_W-1:0] fx_val;
		logic                             fx_expl;
		logic                             fx_sat;
	} word_t;

	typedef struct {
		logic [tqle_pkg::ACT_W-1:0]       act;
		logic signed [tqle_pkg::VAL_W-1:0] val;
		logic                             expl;
		logic                             sat;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write = 1'b0;
	logic [tqle_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tqle_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = '0;
	logic [tqle_pkg::STATE_W-1:0] state_index = '0;
	logic [tqle_pkg::ACT_W-1:0] action_index = '0;
	logic signed [tqle_pkg::VAL_W-1:0] reward = '0;
	logic [tqle_pkg::STATE_W-1:0] succ_state = '0;
	logic [tqle_pkg::ACT_W-1:0] succ_action = '0;
	logic [tqle_pkg::FRAC_W-1:0] random_fraction = '0;
	logic [tqle_pkg::ACT_W-1:0] random_action = '0;
	logic signed [tqle_pkg::VAL_W-1:0] entry_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [tqle_pkg::ACT_W-1:0] chosen_action;
	logic signed [tqle_pkg::VAL_W-1:0] table_value;
	logic explored;
	logic saturated;

	tabular_q_learning_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .state_index(state_index), .action_index(action_index),
		.reward(reward), .succ_state(succ_state), .succ_action(succ_action),
		.random_fraction(random_fraction), .random_action(random_action),
		.entry_value(entry_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.chosen_action(chosen_action), .table_value(table_value),
		.explored(explored), .saturated(saturated)
	);

	// Shadow of the engine: value table and register copies.
	logic signed [tqle_pkg::VAL_W-1:0] q_shadow [tqle_pkg::DEPTH];
	logic [15:0] alpha_r = tqle_pkg::LEARN_RATE_RST;
	logic [15:0] gamma_r = tqle_pkg::DISCOUNT_RST;
	logic [tqle_pkg::EPS_W-1:0] eps_r = tqle_pkg::EXPLORE_RATE_RST;
	logic mode_r = tqle_pkg::UPDATE_MODE_RST;
	logic [tqle_pkg::NACT_W-1:0] nact_r = tqle_pkg::NUM_ACTIONS_RST;

	outcome_t pending_results[$];
	word_t offered;
	int err_count = 0;
	int cycles = 0;
	int words_sent = 0;
	int results_seen = 0;
	int explore_seen = 0;
	int sat_seen = 0;
	bit hold_rx = 1'b0;
	bit random_running = 1'b0;
	int burst_left = 0;

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int unsigned cols_in_use();
		if (nact_r == 0)
			return 1;
		if (nact_r > tqle_pkg::NUM_ACTIONS)
			return tqle_pkg::NUM_ACTIONS;
		return nact_r;
	endfunction

	// First column holding the row maximum, scanning only the actions in use.
	function automatic logic [tqle_pkg::ACT_W-1:0] greedy_col(
			input logic [tqle_pkg::STATE_W-1:0] s);
		logic [tqle_pkg::ACT_W-1:0] best;
		best = '0;
		for (int i = 1; i < cols_in_use(); i++) begin
			if (q_shadow[{s, tqle_pkg::ACT_W'(i)}] > q_shadow[{s, best}])
				best = tqle_pkg::ACT_W'(i);
		end
		return best;
	endfunction

	// Works out one result word and applies the table side effect.
	function automatic outcome_t predict_outcome(input word_t w);
		outcome_t r;
		longint q, target, term, delta, nv;
		longint unsigned m, hi, lo, mag;
		bit neg;
		r = '{act: '0, val: '0, expl: 1'b0, sat: 1'b0};
		case (w.op)
			tqle_pkg::CMD_SELECT: begin
				if (w.frac < eps_r) begin
					r.act = (w.ract < cols_in_use()) ? w.ract
						: tqle_pkg::ACT_W'(cols_in_use() - 1);
					r.expl = 1'b1;
				end else begin
					r.act = greedy_col(w.st);
				end
				r.val = q_shadow[{w.st, r.act}];
			end
			tqle_pkg::CMD_UPDATE: begin
				q = q_shadow[{w.st, w.act}];
				target = mode_r ? q_shadow[{w.nst, greedy_col(w.nst)}]
					: q_shadow[{w.nst, w.nact}];
				term = longint'(w.rew) * 65536 + longint'(gamma_r) * target - q * 65536;
				neg = term < 0;
				m = neg ? -term : term;
				hi = m >> 32;
				lo = m & 64'hFFFF_FFFF;
				// Round half away from zero: the magnitude is rounded, then signed.
				mag = alpha_r * hi + ((alpha_r * lo + 64'h8000_0000) >> 32);
				delta = neg ? -longint'(mag) : longint'(mag);
				nv = q + delta;
				if (nv > 32767) begin
					nv = 32767;
					r.sat = 1'b1;
				end else if (nv < -32768) begin
					nv = -32768;
					r.sat = 1'b1;
				end
				r.val = tqle_pkg::VAL_W'(nv);
				q_shadow[{w.st, w.act}] = r.val;
			end
			tqle_pkg::CMD_WRITE: begin
				r.val = w.ev;
				q_shadow[{w.st, w.act}] = w.ev;
			end
			default: r.val = q_shadow[{w.st, w.act}];
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
		err_count++;
	endtask

	// Monitor: results are checked before the word taken on the same edge is
	// predicted, since that result always belongs to an older word.
	always @(posedge clk) begin
		outcome_t e, p;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", 1, 0);
			end else begin
				e = pending_results.pop_front();
				if (chosen_action !== e.act)
					report_mismatch("chosen_action", chosen_action, e.act);
				if (table_value !== e.val)
					report_mismatch("table_value", table_value, e.val);
				if (explored !== e.expl)
					report_mismatch("explored", explored, e.expl);
				if (saturated !== e.sat)
					report_mismatch("saturated", saturated, e.sat);
			end
		end
		if (arst_n && in_valid && in_ready) begin
			p = predict_outcome(offered);
			explore_seen += p.expl;
			sat_seen += p.sat;
			if (offered.fixed)
				p = '{act: offered.fx_act, val: offered.fx_val,
					expl: offered.fx_expl, sat: offered.fx_sat};
			pending_results.push_back(p);
		end
	end

	// Receiver: segments of steady, moderate and heavy back-pressure, plus a
	// long hold-off requested by the pressure process below.
	initial begin
		int seg, kind;
		forever begin
			seg = $urandom_range(5, 60);
			kind = $urandom_range(0, 2);
			repeat (seg) begin
				@(posedge clk);
				out_ready <= !hold_rx && (kind == 0 ||
					$urandom_range(0, 99) < (kind == 1 ? 50 : 15));
			end
		end
	end

	// Long receiver hold-off once the random run is going, so the output
	// register and the engine both fill and in_ready drops.
	initial begin
		wait (random_running);
		repeat (100) @(posedge clk);
		hold_rx = 1'b1;
		repeat (400) @(posedge clk);
		hold_rx = 1'b0;
	end

	// Drives one word and returns on the edge that takes it; valid stays high
	// so that a following word can go out back to back.
	task automatic send_word(input word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= w.op;
		state_index <= w.st;
		action_index <= w.act;
		reward <= w.rew;
		succ_state <= w.nst;
		succ_action <= w.nact;
		random_fraction <= w.frac;
		random_action <= w.ract;
		entry_value <= w.ev;
		offered <= w;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// Register writes happen only with no word in flight; every word gives a
	// result, so an empty queue means the engine is idle.
	task automatic load_settings(input logic [15:0] lr, input logic [15:0] g,
			input logic [tqle_pkg::EPS_W-1:0] eps, input logic mode,
			input logic [tqle_pkg::NACT_W-1:0] na);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= tqle_pkg::CFG_LEARN_RATE;
		cfg_data <= tqle_pkg::CFG_DATA_W'(lr);
		@(posedge clk);
		cfg_index <= tqle_pkg::CFG_DISCOUNT;
		cfg_data <= tqle_pkg::CFG_DATA_W'(g);
		@(posedge clk);
		cfg_index <= tqle_pkg::CFG_EXPLORE_RATE;
		cfg_data <= tqle_pkg::CFG_DATA_W'(eps);
		@(posedge clk);
		cfg_index <= tqle_pkg::CFG_UPDATE_MODE;
		cfg_data <= tqle_pkg::CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_index <= tqle_pkg::CFG_NUM_ACTIONS;
		cfg_data <= tqle_pkg::CFG_DATA_W'(na);
		@(posedge clk);
		cfg_write <= 1'b0;
		alpha_r = lr;
		gamma_r = g;
		eps_r = eps;
		mode_r = mode;
		nact_r = na;
	endtask

	function automatic word_t mk(input tqle_pkg::cmd_t op, input int s, input int a,
			input int rw, input int ns, input int na, input int rf, input int ra,
			input int ev);
		word_t w;
		w.op = op;
		w.st = tqle_pkg::STATE_W'(s);
		w.act = tqle_pkg::ACT_W'(a);
		w.rew = tqle_pkg::VAL_W'(rw);
		w.nst = tqle_pkg::STATE_W'(ns);
		w.nact = tqle_pkg::ACT_W'(na);
		w.frac = tqle_pkg::FRAC_W'(rf);
		w.ract = tqle_pkg::ACT_W'(ra);
		w.ev = tqle_pkg::VAL_W'(ev);
		w.fixed = 1'b0;
		w.fx_act = '0;
		w.fx_val = '0;
		w.fx_expl = 1'b0;
		w.fx_sat = 1'b0;
		return w;
	endfunction

	function automatic word_t known(input word_t w, input int a, input int v,
			input bit e, input bit s);
		w.fixed = 1'b1;
		w.fx_act = tqle_pkg::ACT_W'(a);
		w.fx_val = tqle_pkg::VAL_W'(v);
		w.fx_expl = e;
		w.fx_sat = s;
		return w;
	endfunction

	function automatic int pick_value();
		case ($urandom_range(0, 7))
			0: return 32767;
			1: return -32768;
			2: return $urandom_range(0, 511) - 256;
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	// Random word: states mostly from a small pool so updates feed on each
	// other, fields at their extremes now and then.
	function automatic word_t random_word();
		int s, ns, rf;
		s = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 255);
		ns = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 255);
		case ($urandom_range(0, 5))
			0: rf = 0;
			1: rf = 65535;
			default: rf = $urandom_range(0, 65535);
		endcase
		return mk(tqle_pkg::cmd_t'($urandom_range(0, 3)), s, $urandom_range(0, 7),
			pick_value(), ns, $urandom_range(0, 7), rf, $urandom_range(0, 7), pick_value());
	endfunction

	initial begin
		word_t directed[$];
		logic [15:0] lr, g;
		logic [tqle_pkg::EPS_W-1:0] eps;
		logic [tqle_pkg::NACT_W-1:0] na;
		logic md;
		arst_n <= 1'b0;
		for (int i = 0; i < tqle_pkg::DEPTH; i++)
			q_shadow[i] = '0;

		// Reset settings: Q-learning, eight actions, epsilon 6554.
		directed.push_back(known(mk(tqle_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 0));
		directed.push_back(known(mk(tqle_pkg::CMD_READ, 255, 7, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 0));
		directed.push_back(known(mk(tqle_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 32767),
			0, 32767, 0, 0));
		directed.push_back(known(mk(tqle_pkg::CMD_WRITE, 255, 7, 0, 0, 0, 0, 0, -32768),
			0, -32768, 0, 0));
		directed.push_back(known(mk(tqle_pkg::CMD_SELECT, 0, 0, 0, 0, 0, 65535, 0, 0),
			0, 32767, 0, 0));
		directed.push_back(known(mk(tqle_pkg::CMD_SELECT, 255, 0, 0, 0, 0, 65535, 0, 0),
			0, 0, 0, 0));
		directed.push_back(known(mk(tqle_pkg::CMD_SELECT, 0, 0, 0, 0, 0, 0, 7, 0),
			7, 0, 1, 0));
		// Maximum reward on top of a full entry clips at the positive end.
		directed.push_back(known(mk(tqle_pkg::CMD_UPDATE, 0, 0, 32767, 0, 0, 0, 0, 0),
			0, 32767, 0, 1));
		directed.push_back(mk(tqle_pkg::CMD_UPDATE, 255, 7, -32768, 255, 0, 0, 0, 0));
		directed.push_back(mk(tqle_pkg::CMD_UPDATE, 1, 3, 256, 0, 0, 0, 0, 0));
		directed.push_back(mk(tqle_pkg::CMD_READ, 1, 3, 0, 0, 0, 0, 0, 0));
		directed.push_back(known(mk(tqle_pkg::CMD_WRITE, 2, 5, 0, 0, 0, 0, 0, -1),
			0, -1, 0, 0));
		// A fraction equal to epsilon does not explore; one below it does.
		directed.push_back(known(mk(tqle_pkg::CMD_SELECT, 2, 0, 0, 0, 0, 6554, 5, 0),
			0, 0, 0, 0));
		directed.push_back(known(mk(tqle_pkg::CMD_SELECT, 2, 0, 0, 0, 0, 6553, 5, 0),
			5, -1, 1, 0));
		// SARSA with three actions, always exploring, full alpha and gamma.
		directed.push_back(mk(tqle_pkg::CMD_SELECT, 0, 0, 0, 0, 0, 65535, 7, 0));
		directed.push_back(mk(tqle_pkg::CMD_WRITE, 3, 6, 0, 0, 0, 0, 0, -32768));
		directed.push_back(mk(tqle_pkg::CMD_WRITE, 3, 0, 0, 0, 0, 0, 0, -30000));
		directed.push_back(mk(tqle_pkg::CMD_UPDATE, 3, 0, -32768, 3, 6, 0, 0, 0));
		directed.push_back(mk(tqle_pkg::CMD_UPDATE, 4, 7, 32767, 0, 0, 0, 0, 0));
		directed.push_back(mk(tqle_pkg::CMD_SELECT, 0, 0, 0, 0, 0, 0, 1, 0));
		// Zero actions in use behaves as one; epsilon zero never explores.
		directed.push_back(mk(tqle_pkg::CMD_SELECT, 0, 0, 0, 0, 0, 0, 6, 0));
		directed.push_back(mk(tqle_pkg::CMD_UPDATE, 5, 2, 100, 0, 0, 0, 0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (i == 14)
				load_settings(16'hFFFF, 16'hFFFF, 17'd65536, 1'b0, 4'd3);
			if (i == 20)
				load_settings(16'd6554, 16'd0, 17'd0, 1'b1, 4'd0);
			send_word(directed[i]);
		end

		random_running = 1'b1;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: lr = 16'd0;
				1: lr = 16'hFFFF;
				default: lr = 16'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 3))
				0: g = 16'd0;
				1: g = 16'hFFFF;
				default: g = 16'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 4))
				0: eps = 17'd0;
				1: eps = 17'd65536;
				2: eps = tqle_pkg::EPS_W'($urandom_range(65537, 131071));
				default: eps = tqle_pkg::EPS_W'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 4))
				0: na = 4'd1;
				1: na = 4'd8;
				2: na = $urandom_range(0, 1) ? 4'd0
					: tqle_pkg::NACT_W'($urandom_range(9, 15));
				default: na = tqle_pkg::NACT_W'($urandom_range(1, 8));
			endcase
			// The first two phases pin both update targets.
			md = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
			load_settings(lr, g, eps, md, na);
			repeat (PHASE_WORDS) send_word(random_word());
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Sent %0d words over %0d register settings; %0d results checked.",
			words_sent, RAND_PHASES + 3, results_seen);
		$display("Predicted %0d exploring selections and %0d clipped updates.",
			explore_seen, sat_seen);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d results missing", err_count,
				pending_results.size());
			$display("FAILURE");
		end
		$finish;
	end
endmodule

`default_nettype wire
